// ----- design/subsystem_heartbeat_watchdog_defines.svh -----
// assertion macros for the subsystem heartbeat watchdog
`ifndef SUBSYSTEM_HEARTBEAT_WATCHDOG_DEFINES_SVH
`define SUBSYSTEM_HEARTBEAT_WATCHDOG_DEFINES_SVH

`ifndef SYNTH
`define HBW_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("heartbeat watchdog check failed");
`define HBW_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heartbeat watchdog implication failed");
`else
`define HBW_ASSERT(name, clk, rst_n, prop)
`define HBW_ASSERT_IMP(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/hbw_pkg.sv -----
// shared types and constants of the subsystem heartbeat watchdog
package hbw_pkg;

  localparam int NumSubsys = 3;
  typedef logic [NumSubsys-1:0] rail_t;

  localparam logic ActTick   = 1'b0;
  localparam logic ActPacket = 1'b1;

  localparam logic [1:0] PtTm = 2'd0;
  localparam logic [1:0] PtTc = 2'd1;

  localparam logic [3:0] AppObc    = 4'd1;
  localparam logic [3:0] AppSystem = 4'd2;
  localparam logic [3:0] AppAdcs   = 4'd3;
  localparam logic [3:0] AppComms  = 4'd4;
  localparam logic [3:0] AppGnd    = 4'd6;
  localparam logic [3:0] AppDbg    = 4'd7;
  localparam logic [3:0] AppLimit  = 4'd8;

  localparam logic [7:0] SvcHk   = 8'd3;
  localparam logic [7:0] SvcFm   = 8'd8;
  localparam logic [7:0] SvcTest = 8'd17;

  localparam logic [2:0] RtNone = 3'd0;
  localparam logic [2:0] RtHk   = 3'd1;
  localparam logic [2:0] RtFm   = 3'd2;
  localparam logic [2:0] RtTest = 3'd3;
  localparam logic [2:0] RtFwd  = 3'd4;

  localparam int SlotObc   = 0;
  localparam int SlotAdcs  = 1;
  localparam int SlotComms = 2;

  localparam logic [31:0] TimeoutReset = 32'd600000;

  localparam int QDepth = 4;
  localparam int QAddrW = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic        action;
    logic [31:0] time_now;
    logic [1:0]  packet_type;
    logic [3:0]  source_app;
    logic [3:0]  dest_app;
    logic [7:0]  service_type;
    rail_t       rails_on;
  } in_item_t;

  typedef struct packed {
    logic  status;
    logic [2:0] route;
    rail_t rail_on_cmd;
    rail_t rail_off_cmd;
  } out_item_t;

  typedef struct packed {
    logic        action;
    logic [31:0] time_now;
    rail_t       rails_on;
    logic        status;
    logic [2:0]  route;
    rail_t       stamp;
  } cmd_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } q_status_t;

endpackage

// ----- design/hbw_front.sv -----
// front end: request accept, header validation and classification
module hbw_front import hbw_pkg::*; (
  input  logic      push,
  input  in_item_t  item_i,
  input  q_status_t q_stat_i,
  output logic      q_push_o,
  output cmd_t      cmd_o
);

  logic       hdr_ok;
  logic [3:0] rid;

  assign q_push_o = push && !q_stat_i.full;

  always_comb begin
    hdr_ok = ((item_i.packet_type == PtTc) || (item_i.packet_type == PtTm)) &&
             (item_i.source_app < AppLimit) && (item_i.dest_app < AppLimit);
    rid = (item_i.packet_type == PtTc) ? item_i.source_app : item_i.dest_app;

    cmd_o.action   = item_i.action;
    cmd_o.time_now = item_i.time_now;
    cmd_o.rails_on = item_i.rails_on;
    cmd_o.status   = 1'b0;
    cmd_o.route    = RtNone;
    cmd_o.stamp    = '0;

    if (item_i.action == ActPacket) begin
      if (!hdr_ok) begin
        cmd_o.status = 1'b1;
      end else begin
        cmd_o.stamp[SlotObc]   = (rid == AppObc);
        cmd_o.stamp[SlotAdcs]  = (rid == AppAdcs);
        cmd_o.stamp[SlotComms] = (rid == AppComms);
        if (rid == AppSystem) begin
          case (item_i.service_type)
            SvcHk:   cmd_o.route = RtHk;
            SvcFm:   cmd_o.route = RtFm;
            SvcTest: cmd_o.route = RtTest;
            default: cmd_o.route = RtNone;
          endcase
        end else if ((rid == AppObc) || (rid == AppAdcs) || (rid == AppComms) ||
                     (rid == AppGnd) || (rid == AppDbg)) begin
          cmd_o.route = RtFwd;
        end
      end
    end
  end

endmodule

// ----- design/hbw_queue.sv -----
// short request queue between front and back end
module hbw_queue import hbw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      data_i,
  input  logic      pop_i,
  output cmd_t      data_o,
  output q_status_t stat_o
);

  cmd_t              mem_q [QDepth];
  logic [QAddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
  assign data_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAddrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAddrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/hbw_back.sv -----
// back end: timestamps, timeout checks, restart sequencing and result register
module hbw_back import hbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] timeout_i,
  input  cmd_t        cmd_i,
  input  logic        cmd_valid_i,
  output logic        cmd_pop_o,
  input  logic        pop,
  output logic        empty,
  output out_item_t   result_o
);

  logic [31:0] last_seen_q [NumSubsys];
  logic [31:0] last_seen_d [NumSubsys];
  logic [31:0] elapsed     [NumSubsys];
  rail_t       pending_q, pending_d;
  rail_t       expired;
  out_item_t   res_q, res_d;
  logic        res_valid_q;
  logic        take;

  assign take      = cmd_valid_i && (!res_valid_q || pop);
  assign cmd_pop_o = take;
  assign empty     = !res_valid_q;
  assign result_o  = res_q;

  always_comb begin
    pending_d = pending_q;
    res_d     = '0;
    for (int i = 0; i < NumSubsys; i++) begin
      elapsed[i]     = cmd_i.time_now - last_seen_q[i];
      expired[i]     = elapsed[i] > timeout_i;
      last_seen_d[i] = last_seen_q[i];
    end
    res_d.status = cmd_i.status;
    res_d.route  = cmd_i.route;
    if (cmd_i.action == ActPacket) begin
      for (int i = 0; i < NumSubsys; i++) begin
        if (cmd_i.stamp[i]) begin
          last_seen_d[i] = cmd_i.time_now;
        end
      end
    end else begin
      // restarted rails restamp now and are masked out, so they cannot expire on this tick
      res_d.rail_on_cmd  = pending_q;
      res_d.rail_off_cmd = expired & cmd_i.rails_on & ~pending_q;
      pending_d          = res_d.rail_off_cmd;
      for (int i = 0; i < NumSubsys; i++) begin
        if (pending_q[i]) begin
          last_seen_d[i] = cmd_i.time_now;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      pending_q   <= '0;
      for (int i = 0; i < NumSubsys; i++) begin
        last_seen_q[i] <= '0;
      end
    end else begin
      if (take) begin
        res_valid_q <= 1'b1;
        pending_q   <= pending_d;
        for (int i = 0; i < NumSubsys; i++) begin
          last_seen_q[i] <= last_seen_d[i];
        end
      end else if (pop) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

// ----- design/subsystem_heartbeat_watchdog.sv -----
// Subsystem heartbeat watchdog, top level. Takes packet headers and timer ticks
// through a queue-style port and returns one result per request in order.
// Headers are validated and routed in the front end; heartbeat stamps, the
// timeout test against the timeout register and power-cycle restart commands are
// done in the back end. A four-entry queue sits between the two and a result
// register drives the output, so a new request is taken every cycle while the
// queue has room and the result is empty or popped; each request passes through
// the queue, then the result register. Three 32-bit elapsed-time compares run in
// the back end per request. No clearing pass is needed after reset.
`include "subsystem_heartbeat_watchdog_defines.svh"

module subsystem_heartbeat_watchdog import hbw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  in_item_t    item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   result_o
);

  logic [31:0] timeout_q;
  q_status_t   q_stat;
  cmd_t        front_cmd, q_cmd;
  logic        q_push, q_pop;
  logic        res_cmd_overlap;
  logic        res_quiet;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  assign full = q_stat.full;

  hbw_front u_front (
    .push     (push),
    .item_i   (item_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .cmd_o    (front_cmd)
  );

  hbw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (front_cmd),
    .pop_i  (q_pop),
    .data_o (q_cmd),
    .stat_o (q_stat)
  );

  hbw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .cmd_i       (q_cmd),
    .cmd_valid_i (!q_stat.empty),
    .cmd_pop_o   (q_pop),
    .pop         (pop),
    .empty       (empty),
    .result_o    (result_o)
  );

  assign res_cmd_overlap = |(result_o.rail_on_cmd & result_o.rail_off_cmd);
  assign res_quiet       = (result_o.route == RtNone) && (result_o.rail_on_cmd == '0) &&
                           (result_o.rail_off_cmd == '0);

  `HBW_ASSERT(a_q_count_bound, clk_i, rst_ni, q_stat.count <= QCntW'(QDepth))
  `HBW_ASSERT_IMP(a_rail_cmd_disjoint, clk_i, rst_ni, !empty, !res_cmd_overlap)
  `HBW_ASSERT_IMP(a_bad_hdr_quiet, clk_i, rst_ni, !empty && result_o.status, res_quiet)

endmodule

// ----- tb/subsystem_heartbeat_watchdog_tb.sv -----
// testbench for the subsystem heartbeat watchdog: directed and random requests checked in order
`timescale 1ns / 1ps

module subsystem_heartbeat_watchdog_tb;
  import hbw_pkg::*;

  localparam int StallLimit   = 1000;
  localparam int SettleCycles = 4;
  localparam int PhaseItems   = 125;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        push;
  logic        full;
  in_item_t    item_i;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result_o;

  // watchdog model state
  logic [31:0] seen_model [NumSubsys];
  rail_t       restart_model;
  logic [31:0] timeout_model;

  out_item_t   expected_results [$];
  out_item_t   head_result;
  int          failures = 0;
  int          stall_cycles = 0;
  logic        steady;
  logic [31:0] sim_now;

  subsystem_heartbeat_watchdog u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_item_t heartbeat_predict(input in_item_t req);
    out_item_t   r;
    logic [3:0]  id;
    rail_t       rails;
    logic [31:0] elapsed;
    r = '0;
    if (req.action == ActPacket) begin
      if ((req.packet_type != PtTm && req.packet_type != PtTc) ||
          req.source_app >= AppLimit || req.dest_app >= AppLimit) begin
        r.status = 1'b1;
      end else begin
        id = (req.packet_type == PtTc) ? req.source_app : req.dest_app;
        if (id == AppObc) seen_model[SlotObc] = req.time_now;
        if (id == AppAdcs) seen_model[SlotAdcs] = req.time_now;
        if (id == AppComms) seen_model[SlotComms] = req.time_now;
        if (id == AppSystem) begin
          if (req.service_type == SvcHk) r.route = RtHk;
          else if (req.service_type == SvcFm) r.route = RtFm;
          else if (req.service_type == SvcTest) r.route = RtTest;
        end else if (id == AppObc || id == AppAdcs || id == AppComms ||
                     id == AppGnd || id == AppDbg) begin
          r.route = RtFwd;
        end
      end
    end else begin
      for (int i = 0; i < NumSubsys; i++) begin
        if (restart_model[i]) begin
          r.rail_on_cmd[i] = 1'b1;
          seen_model[i] = req.time_now;
        end
      end
      restart_model = '0;
      // a rail switched on now counts as on
      rails = req.rails_on | r.rail_on_cmd;
      for (int i = 0; i < NumSubsys; i++) begin
        elapsed = req.time_now - seen_model[i];
        if (elapsed > timeout_model && rails[i]) begin
          restart_model[i] = 1'b1;
          r.rail_off_cmd[i] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  function automatic in_item_t packet_req(input logic [1:0] ptype, input logic [3:0] src,
                                          input logic [3:0] dst, input logic [7:0] svc,
                                          input logic [31:0] now);
    in_item_t req;
    req.action       = ActPacket;
    req.time_now     = now;
    req.packet_type  = ptype;
    req.source_app   = src;
    req.dest_app     = dst;
    req.service_type = svc;
    req.rails_on     = rail_t'($urandom_range(0, 7));
    return req;
  endfunction

  function automatic in_item_t tick_req(input logic [31:0] now, input rail_t rails);
    in_item_t req;
    req.action       = ActTick;
    req.time_now     = now;
    req.packet_type  = 2'($urandom_range(0, 3));
    req.source_app   = 4'($urandom_range(0, 15));
    req.dest_app     = 4'($urandom_range(0, 15));
    req.service_type = 8'($urandom_range(0, 255));
    req.rails_on     = rails;
    return req;
  endfunction

  function automatic in_item_t random_request(input logic [31:0] now);
    in_item_t   req;
    logic [7:0] svc;
    if ($urandom_range(0, 99) < 15) begin
      req.action       = 1'($urandom_range(0, 1));
      req.time_now     = $urandom;
      req.packet_type  = 2'($urandom_range(0, 3));
      req.source_app   = 4'($urandom_range(0, 15));
      req.dest_app     = 4'($urandom_range(0, 15));
      req.service_type = 8'($urandom_range(0, 255));
      req.rails_on     = rail_t'($urandom_range(0, 7));
    end else if ($urandom_range(0, 99) < 45) begin
      req = tick_req(now, ($urandom_range(0, 3) == 0) ? rail_t'($urandom_range(0, 7)) : '1);
    end else begin
      case ($urandom_range(0, 3))
        0: svc = SvcHk;
        1: svc = SvcFm;
        2: svc = SvcTest;
        default: svc = 8'($urandom_range(0, 255));
      endcase
      req = packet_req($urandom_range(0, 1) ? PtTc : PtTm, 4'($urandom_range(0, 7)),
                       4'($urandom_range(0, 7)), svc, now);
    end
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    if (!steady && $urandom_range(0, 99) < 9) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= req;
    do @(posedge clk_i); while (full);
    expected_results.push_back(heartbeat_predict(req));
  endtask

  task automatic settle();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    timeout_model = value;
  endtask

  task automatic test_packet_routing();
    send_request(packet_req(PtTc, AppSystem, 4'd0, SvcHk, 32'd10));
    send_request(packet_req(PtTc, AppSystem, 4'd7, SvcFm, 32'd11));
    send_request(packet_req(PtTc, AppSystem, 4'd5, SvcTest, 32'd12));
    send_request(packet_req(PtTc, AppSystem, 4'd1, 8'd0, 32'd13));
    send_request(packet_req(PtTc, AppSystem, 4'd3, 8'd255, 32'd14));
    send_request(packet_req(PtTm, 4'd7, AppObc, SvcHk, 32'd0));
    send_request(packet_req(PtTm, 4'd0, AppAdcs, SvcFm, 32'hFFFF_FFFF));
    send_request(packet_req(PtTm, 4'd2, AppComms, 8'd255, 32'h8000_0000));
    send_request(packet_req(PtTm, 4'd1, AppGnd, SvcTest, 32'd20));
    send_request(packet_req(PtTm, 4'd4, AppDbg, 8'd0, 32'd21));
    send_request(packet_req(PtTm, 4'd1, 4'd0, SvcHk, 32'd22));
    send_request(packet_req(PtTc, 4'd5, AppComms, SvcHk, 32'd23));
    send_request(packet_req(2'd2, AppObc, AppObc, SvcHk, 32'd24));
    send_request(packet_req(2'd3, AppSystem, AppSystem, SvcFm, 32'd25));
    send_request(packet_req(PtTc, 4'd8, AppAdcs, SvcHk, 32'd26));
    send_request(packet_req(PtTm, 4'd15, 4'd15, 8'd255, 32'hFFFF_FFFF));
    send_request(packet_req(PtTc, AppObc, 4'd7, 8'd255, 32'd30));
  endtask

  task automatic test_power_cycle();
    write_timeout(32'd10);
    send_request(packet_req(PtTc, AppObc, 4'd0, SvcHk, 32'd100));
    send_request(packet_req(PtTm, 4'd0, AppAdcs, SvcHk, 32'd100));
    send_request(tick_req(32'd105, 3'b111));
    send_request(tick_req(32'd106, 3'b001));
    send_request(tick_req(32'd111, 3'b111));
    send_request(tick_req(32'd120, 3'b000));
    send_request(packet_req(PtTc, AppComms, 4'd1, SvcFm, 32'hFFFF_FFFA));
    send_request(tick_req(32'd3, 3'b100));
    send_request(tick_req(32'd5, 3'b100));
    // zero timeout: a rail restored on this tick is not switched off again
    write_timeout(32'd0);
    send_request(tick_req(32'd5, 3'b111));
    send_request(tick_req(32'd5, 3'b111));
  endtask

  task automatic test_random_phases();
    logic [31:0] timeouts [6];
    logic [31:0] step_max;
    timeouts = '{32'd1, 32'hFFFF_FFFF, TimeoutReset, 32'd0, 32'd37,
                 32'($urandom_range(2, 5000))};
    sim_now = $urandom;
    foreach (timeouts[p]) begin
      write_timeout(timeouts[p]);
      if (timeouts[p] == 32'hFFFF_FFFF) step_max = 32'hFFFF;
      else step_max = (timeouts[p] >> 2) + 32'd2;
      // one phase with no idling on either side
      steady = (p == 4);
      repeat (PhaseItems) begin
        sim_now = sim_now + $urandom_range(0, step_max);
        send_request(random_request(sim_now));
      end
    end
    steady = 1'b0;
  endtask

  // result side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(0, 99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected request result: %p", result_o);
        failures++;
      end else begin
        head_result = expected_results.pop_front();
        if (result_o.status !== head_result.status) begin
          $error("status: expected %0d, got %0d", head_result.status, result_o.status);
          failures++;
        end
        if (result_o.route !== head_result.route) begin
          $error("route: expected %0d, got %0d", head_result.route, result_o.route);
          failures++;
        end
        if (result_o.rail_on_cmd !== head_result.rail_on_cmd) begin
          $error("rail_on_cmd: expected %b, got %b",
                 head_result.rail_on_cmd, result_o.rail_on_cmd);
          failures++;
        end
        if (result_o.rail_off_cmd !== head_result.rail_off_cmd) begin
          $error("rail_off_cmd: expected %b, got %b",
                 head_result.rail_off_cmd, result_o.rail_off_cmd);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("subsystem_heartbeat_watchdog regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    push          = 1'b0;
    item_i        = '0;
    steady        = 1'b0;
    sim_now       = '0;
    timeout_model = TimeoutReset;
    restart_model = '0;
    foreach (seen_model[i]) seen_model[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_packet_routing();
    test_power_cycle();
    test_random_phases();
    settle();

    if (failures == 0) begin
      $display("subsystem_heartbeat_watchdog regression: pass");
    end else begin
      $display("subsystem_heartbeat_watchdog regression: fail");
    end
    $finish;
  end

endmodule
